// ----- sv/bfe_pkg.sv -----
// Shared types, codes and helper functions for the 64b/66b frame extractor.
// Used by bfe_decode and block_64b66b_frame_extractor_top; no dependencies.
`timescale 1ns / 1ps

package bfe_pkg;

  // Sync header codes.
  localparam logic [1:0] SH_DATA = 2'd1;
  localparam logic [1:0] SH_CTRL = 2'd2;

  // Control block types.
  localparam logic [7:0] TYPE_IDLE     = 8'h1e;
  localparam logic [7:0] TYPE_ORD_SET  = 8'h55;
  localparam logic [7:0] TYPE_START_0  = 8'h78;
  localparam logic [7:0] TYPE_START_4  = 8'h33;
  localparam logic [7:0] TYPE_TERM_0   = 8'h87;
  localparam logic [7:0] TYPE_TERM_1   = 8'h99;
  localparam logic [7:0] TYPE_TERM_2   = 8'haa;
  localparam logic [7:0] TYPE_TERM_3   = 8'hb4;
  localparam logic [7:0] TYPE_TERM_4   = 8'hcc;
  localparam logic [7:0] TYPE_TERM_5   = 8'hd2;
  localparam logic [7:0] TYPE_TERM_6   = 8'he1;
  localparam logic [7:0] TYPE_TERM_7   = 8'hff;

  // Preamble byte synthesized in place of the start control character.
  localparam logic [7:0] PREAMBLE_BYTE = 8'h55;

  // Ordered-set sequence codes.
  localparam logic [7:0] OS_LOCAL_FAULT  = 8'h01;
  localparam logic [7:0] OS_REMOTE_FAULT = 8'h02;
  localparam logic [7:0] OS_LINK_INT     = 8'h03;

  localparam int unsigned WordBytes = 8;
  localparam int unsigned WordBits  = 64;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_FRAME        = 3'd1,
    EV_LOCAL_FAULT  = 3'd2,
    EV_REMOTE_FAULT = 3'd3,
    EV_LINK_INT     = 3'd4,
    EV_INVALID_OS   = 3'd5
  } event_e;

  // Decoder state carried from one block to the next.
  typedef struct packed {
    logic   in_frame;
    event_e last_event;
  } state_t;

  // One decoded result word.
  typedef struct packed {
    event_e      event_kind;
    logic        extends_previous;
    logic [63:0] frame_bytes;
    logic [3:0]  byte_count;
    logic        frame_start;
    logic        frame_end;
    logic        frame_abort;
  } result_t;

  // Number of data bytes carried by a terminate control block type.
  function automatic logic [3:0] term_count(input logic [7:0] block_type);
    logic [3:0] cnt;
    unique case (block_type)
      TYPE_TERM_0: cnt = 4'd0;
      TYPE_TERM_1: cnt = 4'd1;
      TYPE_TERM_2: cnt = 4'd2;
      TYPE_TERM_3: cnt = 4'd3;
      TYPE_TERM_4: cnt = 4'd4;
      TYPE_TERM_5: cnt = 4'd5;
      TYPE_TERM_6: cnt = 4'd6;
      TYPE_TERM_7: cnt = 4'd7;
      default:     cnt = 4'd0;
    endcase
    return cnt;
  endfunction

  // Mask that keeps the top cnt bytes of a word.
  function automatic logic [63:0] top_bytes_mask(input logic [3:0] cnt);
    logic [63:0] mask;
    mask = '0;
    for (int j = 0; j < WordBytes; j++) begin
      if (4'(j) < cnt) begin
        mask[WordBits - 1 - 8 * j -: 8] = 8'hff;
      end
    end
    return mask;
  endfunction

endpackage

// ----- sv/bfe_decode.sv -----
// Combinational decode of one 66-bit block against the current frame state.
// Depends on bfe_pkg for codes, types and helper functions.
`timescale 1ns / 1ps

module bfe_decode (
  input  logic [1:0]       sync_header_i,
  input  logic [63:0]      payload_i,
  input  bfe_pkg::state_t  state_i,
  output bfe_pkg::result_t result_o,
  output bfe_pkg::state_t  state_o
);

  logic [7:0]       block_type;
  logic [7:0]       b [8];
  logic [3:0]       tcnt;
  bfe_pkg::event_e  os_kind;

  // Split the payload into bytes, first byte on top.
  always_comb begin
    for (int j = 0; j < bfe_pkg::WordBytes; j++) begin
      b[j] = payload_i[bfe_pkg::WordBits - 1 - 8 * j -: 8];
    end
  end

  assign block_type = b[0];
  assign tcnt       = bfe_pkg::term_count(block_type);

  // Map the ordered-set sequence code to an event kind.
  always_comb begin
    unique case (b[3])
      bfe_pkg::OS_LOCAL_FAULT:  os_kind = bfe_pkg::EV_LOCAL_FAULT;
      bfe_pkg::OS_REMOTE_FAULT: os_kind = bfe_pkg::EV_REMOTE_FAULT;
      bfe_pkg::OS_LINK_INT:     os_kind = bfe_pkg::EV_LINK_INT;
      default:                  os_kind = bfe_pkg::EV_INVALID_OS;
    endcase
  end

  // Main decode: frame data, terminate and abort inside a frame; ordered sets
  // and frame starts outside of one.
  always_comb begin
    result_o = '{
      event_kind:       bfe_pkg::EV_NONE,
      extends_previous: 1'b0,
      frame_bytes:      '0,
      byte_count:       4'd0,
      frame_start:      1'b0,
      frame_end:        1'b0,
      frame_abort:      1'b0
    };
    state_o = state_i;

    if (state_i.in_frame) begin
      result_o.event_kind = bfe_pkg::EV_FRAME;
      if (sync_header_i == bfe_pkg::SH_DATA) begin
        result_o.frame_bytes = payload_i;
        result_o.byte_count  = 4'd8;
      end else if (sync_header_i == bfe_pkg::SH_CTRL) begin
        // Any control block closes the frame; only terminate types carry bytes.
        result_o.byte_count  = tcnt;
        result_o.frame_bytes = {payload_i[55:0], 8'h00} & bfe_pkg::top_bytes_mask(tcnt);
        result_o.frame_end   = 1'b1;
        state_o.in_frame     = 1'b0;
      end else begin
        result_o.frame_abort = 1'b1;
        state_o.in_frame     = 1'b0;
      end
    end else if (sync_header_i == bfe_pkg::SH_CTRL) begin
      if (block_type == bfe_pkg::TYPE_ORD_SET) begin
        if (b[4] != 8'h00 || b[1] != 8'h00 || b[2] != 8'h00 ||
            b[5] != 8'h00 || b[6] != 8'h00) begin
          // Malformed ordered set: always reported fresh.
          result_o.event_kind = bfe_pkg::EV_INVALID_OS;
          state_o.last_event  = bfe_pkg::EV_INVALID_OS;
        end else if (b[3] == b[7]) begin
          result_o.event_kind       = os_kind;
          result_o.extends_previous = (state_i.last_event == os_kind);
          state_o.last_event        = os_kind;
        end
      end else if (block_type == bfe_pkg::TYPE_START_0) begin
        result_o.event_kind  = bfe_pkg::EV_FRAME;
        result_o.frame_bytes = {bfe_pkg::PREAMBLE_BYTE, payload_i[55:0]};
        result_o.byte_count  = 4'd8;
        result_o.frame_start = 1'b1;
        state_o.in_frame     = 1'b1;
        state_o.last_event   = bfe_pkg::EV_FRAME;
      end else if (block_type == bfe_pkg::TYPE_START_4) begin
        result_o.event_kind  = bfe_pkg::EV_FRAME;
        result_o.frame_bytes = {bfe_pkg::PREAMBLE_BYTE, payload_i[23:0], 32'h0};
        result_o.byte_count  = 4'd4;
        result_o.frame_start = 1'b1;
        state_o.in_frame     = 1'b1;
        state_o.last_event   = bfe_pkg::EV_FRAME;
      end
    end
  end

endmodule

// ----- sv/block_64b66b_frame_extractor_top.sv -----
// 64b/66b frame extractor: input register, decode and result register.
// A word accepted into the input register is decoded and held in the result register behind out_valid_o.
// Throughput: one word per cycle while out_stall_i is low; the combinational bfe_decode sets the rate.
// Reset (rst_ni low, asynchronous): both stages empty, not in a frame, no last event.
// Depends on bfe_pkg and bfe_decode.
`timescale 1ns / 1ps

module block_64b66b_frame_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  sync_header_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic        extends_previous_o,
  output logic [63:0] frame_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        frame_start_o,
  output logic        frame_end_o,
  output logic        frame_abort_o
);

  logic             in_valid_q;
  logic [1:0]       hdr_q;
  logic [63:0]      payload_q;
  logic             out_valid_q;
  bfe_pkg::result_t res_q;
  bfe_pkg::result_t res_d;
  bfe_pkg::state_t  state_q;
  bfe_pkg::state_t  state_d;
  logic             advance;
  logic             in_accept;

  // A word moves to the result register when that register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  bfe_decode u_decode (
    .sync_header_i (hdr_q),
    .payload_i     (payload_q),
    .state_i       (state_q),
    .result_o      (res_d),
    .state_o       (state_d)
  );

  // Control state: stage valid flags and frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{in_frame: 1'b0, last_event: bfe_pkg::EV_NONE};
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hdr_q     <= sync_header_i;
      payload_q <= payload_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Result ports.
  assign out_valid_o        = out_valid_q;
  assign event_kind_o       = res_q.event_kind;
  assign extends_previous_o = res_q.extends_previous;
  assign frame_bytes_o      = res_q.frame_bytes;
  assign byte_count_o       = res_q.byte_count;
  assign frame_start_o      = res_q.frame_start;
  assign frame_end_o        = res_q.frame_end;
  assign frame_abort_o      = res_q.frame_abort;

endmodule
